/* design/lhm_pkg.sv */
package lhm_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_TICK_INTERVAL = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COUNT_ENABLE  = 2'd1;

    localparam logic ACT_RESTORE = 1'b0;
    localparam logic ACT_SECONDS = 1'b1;

    localparam logic [31:0] COUNT_MAX         = 32'd3599999;
    localparam logic [31:0] COUNT_ERASED      = 32'hffffffff;
    localparam logic [15:0] TICK_INTERVAL_RST = 16'd10;
    localparam logic        COUNT_ENABLE_RST  = 1'b1;

    localparam logic [5:0] CHAR_ZERO  = 6'd48;
    localparam logic [5:0] CHAR_SPACE = 6'd32;

    localparam int MID_DEPTH_DEF = 4;
    localparam int OUT_DEPTH_DEF = 2;

    typedef struct packed {
        logic        action;
        logic [15:0] seconds_now;
        logic [31:0] restored_value;
    } in_item_t;

    typedef struct packed {
        logic        write_valid;
        logic [1:0]  byte_index;
        logic [7:0]  byte_data;
        logic        last_result;
        logic [31:0] lifetime_count;
        logic [5:0]  hour_thousands_char;
        logic [5:0]  hour_hundreds_char;
        logic [5:0]  hour_tens_char;
        logic [5:0]  hour_units_char;
        logic [5:0]  minute_tens_char;
        logic [5:0]  minute_units_char;
    } out_item_t;

    typedef struct packed {
        logic [31:0] count;
        logic [3:0]  wmask;
    } mid_entry_t;

endpackage

/* design/lifetime_hour_meter_with_backup_top.sv */
// an accepted item passes the mid queue, stages s1 to s6, serializer and result queue
// throughput: one result beat per cycle unless the result queue is full; one to four
// per item; the serializer sets the rate, s1-s6 take an item a cycle when it is free
// reset: async active low; count, last tick and queues clear, tick interval 10, enable 1
module lifetime_hour_meter_with_backup_top #(
    parameter int MID_DEPTH = lhm_pkg::MID_DEPTH_DEF,
    parameter int OUT_DEPTH = lhm_pkg::OUT_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  lhm_pkg::in_item_t                sample,
    output logic                             empty,
    input  logic                             pop,
    output lhm_pkg::out_item_t               result,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lhm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [lhm_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int MID_W = $bits(lhm_pkg::mid_entry_t);
    localparam int OUT_W = $bits(lhm_pkg::out_item_t);

    logic                mid_push;
    logic                mid_full;
    logic                mid_empty;
    logic                mid_pop;
    lhm_pkg::mid_entry_t mid_wr;
    lhm_pkg::mid_entry_t mid_rd;
    logic                out_push;
    logic                out_full;
    lhm_pkg::out_item_t  out_beat;

    assign full = mid_full;

    lhm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .sample    (sample),
        .mid_full  (mid_full),
        .mid_push  (mid_push),
        .mid_entry (mid_wr),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    lhm_fifo #(
        .WIDTH (MID_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mid_push),
        .wr_data (mid_wr),
        .full    (mid_full),
        .rd_en   (mid_pop),
        .rd_data (mid_rd),
        .empty   (mid_empty)
    );

    lhm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid_entry (mid_rd),
        .mid_empty (mid_empty),
        .mid_pop   (mid_pop),
        .out_full  (out_full),
        .out_push  (out_push),
        .out_beat  (out_beat)
    );

    lhm_fifo #(
        .WIDTH (OUT_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (out_push),
        .wr_data (out_beat),
        .full    (out_full),
        .rd_en   (pop),
        .rd_data (result),
        .empty   (empty)
    );

endmodule

/* design/lhm_fifo.sv */
module lhm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slots_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* design/lhm_front.sv */
module lhm_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    input  lhm_pkg::in_item_t                   sample,
    input  logic                                mid_full,
    output logic                                mid_push,
    output lhm_pkg::mid_entry_t                 mid_entry,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lhm_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [lhm_pkg::CFG_DATA_W-1:0]      cfg_data
);

    logic [31:0] count_reg, count_next;
    logic [15:0] last_tick_reg, last_tick_next;
    logic [15:0] tick_interval_reg, tick_interval_next;
    logic        count_enable_reg, count_enable_next;
    logic [15:0] elapsed;
    logic [3:0]  wmask;

    assign cfg_ready = 1'b1;
    assign mid_push  = push && !mid_full;
    assign elapsed   = sample.seconds_now - last_tick_reg;

    always_comb
    begin
        count_next     = count_reg;
        last_tick_next = last_tick_reg;
        wmask          = '0;
        if (sample.action == lhm_pkg::ACT_RESTORE)
        begin
            if (sample.restored_value == lhm_pkg::COUNT_ERASED)
            begin
                count_next = '0;
                wmask      = '1;
            end
            else
            begin
                count_next = sample.restored_value;
            end
        end
        else if (count_enable_reg && (elapsed >= tick_interval_reg))
        begin
            count_next = (count_reg >= lhm_pkg::COUNT_MAX - 32'd1) ?
                         lhm_pkg::COUNT_MAX : count_reg + 32'd1;
            last_tick_next = sample.seconds_now;
            for (int b = 0; b < 4; b++)
            begin
                wmask[b] = (count_reg[8*b +: 8] != count_next[8*b +: 8]);
            end
        end
    end

    assign mid_entry.count = count_next;
    assign mid_entry.wmask = wmask;

    always_comb
    begin
        tick_interval_next = tick_interval_reg;
        count_enable_next  = count_enable_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                lhm_pkg::CFG_TICK_INTERVAL: tick_interval_next = cfg_data;
                lhm_pkg::CFG_COUNT_ENABLE:  count_enable_next  = cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg         <= '0;
            last_tick_reg     <= '0;
            tick_interval_reg <= lhm_pkg::TICK_INTERVAL_RST;
            count_enable_reg  <= lhm_pkg::COUNT_ENABLE_RST;
        end
        else
        begin
            tick_interval_reg <= tick_interval_next;
            count_enable_reg  <= count_enable_next;
            if (mid_push)
            begin
                count_reg     <= count_next;
                last_tick_reg <= last_tick_next;
            end
        end
    end

endmodule

/* design/lhm_back.sv */
module lhm_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lhm_pkg::mid_entry_t  mid_entry,
    input  logic                 mid_empty,
    output logic                 mid_pop,
    input  logic                 out_full,
    output logic                 out_push,
    output lhm_pkg::out_item_t   out_beat
);

    localparam logic [30:0] RECIP_45  = 31'd1527099483;
    localparam logic [23:0] RECIP_10K = 24'd13743895;

    logic adv;

    // stage 1: count/8 times reciprocal of 45
    logic        s1_v_reg;
    logic [31:0] s1_cnt_reg;
    logic [3:0]  s1_mask_reg;
    logic [59:0] s1_prod_reg;

    // stage 2: corrected quotient by 360 and remainder
    logic        s2_v_reg;
    logic [31:0] s2_cnt_reg;
    logic [3:0]  s2_mask_reg;
    logic [23:0] s2_hfull_reg;
    logic [8:0]  s2_rem_reg;
    logic [28:0] s2_x;
    logic [23:0] s2_q;
    logic [28:0] s2_r_wide;
    logic [6:0]  s2_r;
    logic [23:0] s2_hfull;
    logic [5:0]  s2_r45;

    // stage 3: hours times reciprocal of 10000, minutes
    logic        s3_v_reg;
    logic [31:0] s3_cnt_reg;
    logic [3:0]  s3_mask_reg;
    logic [23:0] s3_hfull_reg;
    logic [47:0] s3_prod_reg;
    logic [5:0]  s3_min_reg;
    logic [15:0] s3_min_prod;

    // stage 4: hours mod 10000, minute digits
    logic        s4_v_reg;
    logic [31:0] s4_cnt_reg;
    logic [3:0]  s4_mask_reg;
    logic [13:0] s4_hmod_reg;
    logic [2:0]  s4_mt_reg;
    logic [3:0]  s4_mu_reg;
    logic [10:0] s4_est;
    logic [23:0] s4_hm_wide;
    logic [13:0] s4_hmod;
    logic [13:0] s4_mt_prod;
    logic [2:0]  s4_mt;

    // stage 5: hours by 1000, 100 and 10
    logic        s5_v_reg;
    logic [31:0] s5_cnt_reg;
    logic [3:0]  s5_mask_reg;
    logic [13:0] s5_hmod_reg;
    logic [2:0]  s5_mt_reg;
    logic [3:0]  s5_mu_reg;
    logic [3:0]  s5_th_reg;
    logic [6:0]  s5_hh_reg;
    logic [9:0]  s5_ht_reg;
    logic [26:0] s5_th_prod;
    logic [26:0] s5_hh_prod;
    logic [26:0] s5_ht_prod;

    // stage 6: ascii digits
    logic        s6_v_reg;
    logic [31:0] s6_cnt_reg;
    logic [3:0]  s6_mask_reg;
    logic [5:0]  s6_c3_reg, s6_c2_reg, s6_c1_reg, s6_c0_reg, s6_mt_reg, s6_mu_reg;
    logic [3:0]  s6_d2, s6_d1, s6_d0;
    logic [6:0]  s6_d2_wide;
    logic [9:0]  s6_d1_wide;
    logic [13:0] s6_d0_wide;
    logic        s6_b3, s6_b2, s6_b1;

    // serializer
    logic        ser_v_reg;
    logic [31:0] ser_cnt_reg;
    logic [3:0]  ser_mask_reg, ser_mask_next;
    logic [5:0]  ser_c3_reg, ser_c2_reg, ser_c1_reg, ser_c0_reg, ser_mt_reg, ser_mu_reg;
    logic [1:0]  ser_sel;
    logic        ser_wv;
    logic        ser_last;
    logic        ser_done;

    assign mid_pop = adv && !mid_empty;

    assign s2_x      = s1_cnt_reg[31:3];
    assign s2_q      = s1_prod_reg[59:36];
    assign s2_r_wide = s2_x - 29'(30'(s2_q) * 30'd45);
    assign s2_r      = s2_r_wide[6:0];
    assign s2_hfull  = (s2_r >= 7'd45) ? s2_q + 24'd1 : s2_q;
    assign s2_r45    = (s2_r >= 7'd45) ? 6'(s2_r - 7'd45) : s2_r[5:0];

    assign s3_min_prod = 16'(s2_rem_reg) * 16'd171;

    assign s4_est     = s3_prod_reg[47:37];
    assign s4_hm_wide = s3_hfull_reg - 24'(24'(s4_est) * 24'd10000);
    assign s4_hmod    = (s4_hm_wide >= 24'd10000) ? 14'(s4_hm_wide - 24'd10000)
                                                  : s4_hm_wide[13:0];
    assign s4_mt_prod = 14'(s3_min_reg) * 14'd205;
    assign s4_mt      = s4_mt_prod[13:11];

    assign s5_th_prod = 27'(s4_hmod_reg) * 27'd8389;
    assign s5_hh_prod = 27'(s4_hmod_reg) * 27'd10486;
    assign s5_ht_prod = 27'(s4_hmod_reg) * 27'd13108;

    assign s6_d2_wide = s5_hh_reg - 7'(7'(s5_th_reg) * 7'd10);
    assign s6_d1_wide = s5_ht_reg - 10'(10'(s5_hh_reg) * 10'd10);
    assign s6_d0_wide = s5_hmod_reg - 14'(14'(s5_ht_reg) * 14'd10);
    assign s6_d2      = s6_d2_wide[3:0];
    assign s6_d1      = s6_d1_wide[3:0];
    assign s6_d0      = s6_d0_wide[3:0];
    assign s6_b3      = (s5_th_reg == 4'd0);
    assign s6_b2      = s6_b3 && (s6_d2 == 4'd0);
    assign s6_b1      = s6_b2 && (s6_d1 == 4'd0);

    always_comb
    begin
        if (ser_mask_reg[0])
        begin
            ser_sel = 2'd0;
        end
        else if (ser_mask_reg[1])
        begin
            ser_sel = 2'd1;
        end
        else if (ser_mask_reg[2])
        begin
            ser_sel = 2'd2;
        end
        else
        begin
            ser_sel = 2'd3;
        end
    end

    assign ser_wv        = |ser_mask_reg;
    assign ser_mask_next = ser_mask_reg & ~(4'b0001 << ser_sel);
    assign ser_last      = (ser_mask_next == 4'b0000);
    assign out_push      = ser_v_reg && !out_full;
    assign ser_done      = out_push && ser_last;
    assign adv           = !ser_v_reg || ser_done;

    always_comb
    begin
        out_beat.write_valid         = ser_wv;
        out_beat.byte_index          = ser_wv ? ser_sel : 2'd0;
        out_beat.byte_data           = ser_wv ? ser_cnt_reg[{ser_sel, 3'b000} +: 8] : 8'd0;
        out_beat.last_result         = ser_last;
        out_beat.lifetime_count      = ser_cnt_reg;
        out_beat.hour_thousands_char = ser_c3_reg;
        out_beat.hour_hundreds_char  = ser_c2_reg;
        out_beat.hour_tens_char      = ser_c1_reg;
        out_beat.hour_units_char     = ser_c0_reg;
        out_beat.minute_tens_char    = ser_mt_reg;
        out_beat.minute_units_char   = ser_mu_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            s4_v_reg  <= 1'b0;
            s5_v_reg  <= 1'b0;
            s6_v_reg  <= 1'b0;
            ser_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_v_reg  <= mid_pop;
            s2_v_reg  <= s1_v_reg;
            s3_v_reg  <= s2_v_reg;
            s4_v_reg  <= s3_v_reg;
            s5_v_reg  <= s4_v_reg;
            s6_v_reg  <= s5_v_reg;
            ser_v_reg <= s6_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_cnt_reg   <= mid_entry.count;
            s1_mask_reg  <= mid_entry.wmask;
            s1_prod_reg  <= 60'(mid_entry.count[31:3]) * 60'(RECIP_45);

            s2_cnt_reg   <= s1_cnt_reg;
            s2_mask_reg  <= s1_mask_reg;
            s2_hfull_reg <= s2_hfull;
            s2_rem_reg   <= {s2_r45, s1_cnt_reg[2:0]};

            s3_cnt_reg   <= s2_cnt_reg;
            s3_mask_reg  <= s2_mask_reg;
            s3_hfull_reg <= s2_hfull_reg;
            s3_prod_reg  <= 48'(s2_hfull_reg) * 48'(RECIP_10K);
            s3_min_reg   <= s3_min_prod[15:10];

            s4_cnt_reg   <= s3_cnt_reg;
            s4_mask_reg  <= s3_mask_reg;
            s4_hmod_reg  <= s4_hmod;
            s4_mt_reg    <= s4_mt;
            s4_mu_reg    <= 4'(s3_min_reg - 6'(6'(s4_mt) * 6'd10));

            s5_cnt_reg   <= s4_cnt_reg;
            s5_mask_reg  <= s4_mask_reg;
            s5_hmod_reg  <= s4_hmod_reg;
            s5_mt_reg    <= s4_mt_reg;
            s5_mu_reg    <= s4_mu_reg;
            s5_th_reg    <= s5_th_prod[26:23];
            s5_hh_reg    <= s5_hh_prod[26:20];
            s5_ht_reg    <= s5_ht_prod[26:17];

            s6_cnt_reg   <= s5_cnt_reg;
            s6_mask_reg  <= s5_mask_reg;
            s6_c3_reg    <= s6_b3 ? lhm_pkg::CHAR_SPACE : lhm_pkg::CHAR_ZERO + 6'(s5_th_reg);
            s6_c2_reg    <= s6_b2 ? lhm_pkg::CHAR_SPACE : lhm_pkg::CHAR_ZERO + 6'(s6_d2);
            s6_c1_reg    <= s6_b1 ? lhm_pkg::CHAR_SPACE : lhm_pkg::CHAR_ZERO + 6'(s6_d1);
            s6_c0_reg    <= lhm_pkg::CHAR_ZERO + 6'(s6_d0);
            s6_mt_reg    <= lhm_pkg::CHAR_ZERO + 6'(s5_mt_reg);
            s6_mu_reg    <= lhm_pkg::CHAR_ZERO + 6'(s5_mu_reg);

            ser_cnt_reg  <= s6_cnt_reg;
            ser_mask_reg <= s6_mask_reg;
            ser_c3_reg   <= s6_c3_reg;
            ser_c2_reg   <= s6_c2_reg;
            ser_c1_reg   <= s6_c1_reg;
            ser_c0_reg   <= s6_c0_reg;
            ser_mt_reg   <= s6_mt_reg;
            ser_mu_reg   <= s6_mu_reg;
        end
        else if (out_push)
        begin
            ser_mask_reg <= ser_mask_next;
        end
    end

endmodule

/* design/lhm_checker.sv */
module lhm_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               empty,
    input logic               pop,
    input lhm_pkg::out_item_t result
);

    // a waiting beat holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(!empty && !pop) && !$past(!rst_n)) |-> $stable(result))
        else $error("result beat changed while waiting");

    // a beat without a write is always the only one of its item
    a_nowrite: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result.write_valid) |->
            (result.last_result && result.byte_index == 2'd0 && result.byte_data == 8'd0))
        else $error("non-write beat malformed");

    // beats of one item share the count and climb in byte order
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && $past(!empty && pop && !result.last_result)) |->
            (result.lifetime_count == $past(result.lifetime_count) &&
             result.byte_index > $past(result.byte_index) && result.write_valid))
        else $error("beats of one item out of order");

    // written byte matches the count
    a_data: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.write_valid) |->
            (result.byte_data == result.lifetime_count[{result.byte_index, 3'b000} +: 8]))
        else $error("written byte does not match count");

    // hour units and minute tens digits are never blanked
    a_digits: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |->
            (result.hour_units_char >= 6'd48 && result.hour_units_char <= 6'd57 &&
             result.minute_tens_char >= 6'd48 && result.minute_tens_char <= 6'd53))
        else $error("display digit out of range");

endmodule

bind lifetime_hour_meter_with_backup_top lhm_checker u_lhm_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);

/* tb/sv/tb_lifetime_hour_meter_with_backup_top.sv */
module tb_lifetime_hour_meter_with_backup_top;

    localparam int          CLK_HALF        = 5;
    localparam int          RESET_CYCLES    = 7;
    localparam int          SETTLE_CYCLES   = 14;
    localparam int          LONG_HOLD       = 120;
    localparam int          WATCHDOG_LIMIT  = 2000;
    localparam logic [31:0] TICKS_PER_HOUR  = 32'd360;
    localparam logic [31:0] TICKS_PER_MIN   = 32'd6;
    localparam int          RANDOM_PHASES   = 7;
    localparam int          ITEMS_PER_PHASE = 18;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            push      = 1'b0;
    logic                            full;
    lhm_pkg::in_item_t               in_beat   = '0;
    logic                            empty;
    logic                            pop       = 1'b0;
    lhm_pkg::out_item_t              out_beat;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [lhm_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [lhm_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

    // predictor state
    logic [31:0] meter_count       = '0;
    logic [31:0] saved_count       = '0;
    logic [15:0] last_tick_secs    = '0;
    logic [15:0] tick_interval_reg = lhm_pkg::TICK_INTERVAL_RST;
    logic        count_enable_reg  = lhm_pkg::COUNT_ENABLE_RST;

    lhm_pkg::out_item_t expected_beats[$];

    bit hold_request = 1'b0;
    bit steady_mode  = 1'b0;

    int n_errors     = 0;
    int n_samples    = 0;
    int n_restores   = 0;
    int n_beats      = 0;
    int n_writes     = 0;
    int n_cfg_writes = 0;
    int full_stalls  = 0;
    int idle_cycles  = 0;

    lifetime_hour_meter_with_backup_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .sample    (in_beat),
        .empty     (empty),
        .pop       (pop),
        .result    (out_beat),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    function automatic logic [5:0] digit_char(input logic [31:0] digit);
        return lhm_pkg::CHAR_ZERO + digit[5:0];
    endfunction

    function automatic lhm_pkg::out_item_t meter_beat(input logic wv, input logic [1:0] idx,
                                                      input logic [7:0] data);
        lhm_pkg::out_item_t r;
        logic [31:0]        hours;
        logic [31:0]        minutes;
        hours   = (meter_count / TICKS_PER_HOUR) % 32'd10000;
        minutes = (meter_count % TICKS_PER_HOUR) / TICKS_PER_MIN;
        r = '0;
        r.write_valid         = wv;
        r.byte_index          = idx;
        r.byte_data           = data;
        r.lifetime_count      = meter_count;
        r.hour_thousands_char = digit_char(hours / 32'd1000);
        r.hour_hundreds_char  = digit_char((hours % 32'd1000) / 32'd100);
        r.hour_tens_char      = digit_char((hours % 32'd100) / 32'd10);
        r.hour_units_char     = digit_char(hours % 32'd10);
        r.minute_tens_char    = digit_char((minutes % 32'd60) / 32'd10);
        r.minute_units_char   = digit_char(minutes % 32'd10);
        // leading zero blanking, units digit always shown
        if (r.hour_thousands_char == lhm_pkg::CHAR_ZERO)
        begin
            r.hour_thousands_char = lhm_pkg::CHAR_SPACE;
            if (r.hour_hundreds_char == lhm_pkg::CHAR_ZERO)
            begin
                r.hour_hundreds_char = lhm_pkg::CHAR_SPACE;
                if (r.hour_tens_char == lhm_pkg::CHAR_ZERO)
                begin
                    r.hour_tens_char = lhm_pkg::CHAR_SPACE;
                end
            end
        end
        return r;
    endfunction

    function automatic void predict_meter(input lhm_pkg::in_item_t s);
        lhm_pkg::out_item_t beats[$];
        logic [31:0]        diff;
        logic [15:0]        elapsed;
        if (s.action == lhm_pkg::ACT_RESTORE)
        begin
            n_restores++;
            if (s.restored_value == lhm_pkg::COUNT_ERASED)
            begin
                meter_count = '0;
                for (int b = 0; b < 4; b++)
                begin
                    beats.push_back(meter_beat(1'b1, b[1:0], 8'h00));
                end
            end
            else
            begin
                meter_count = s.restored_value;
            end
            saved_count = meter_count;
        end
        else if (count_enable_reg)
        begin
            elapsed = s.seconds_now - last_tick_secs;
            if (elapsed >= tick_interval_reg)
            begin
                if (meter_count >= lhm_pkg::COUNT_MAX - 32'd1)
                begin
                    meter_count = lhm_pkg::COUNT_MAX;
                end
                else
                begin
                    meter_count = meter_count + 32'd1;
                end
                last_tick_secs = s.seconds_now;
                diff = saved_count ^ meter_count;
                for (int b = 0; b < 4; b++)
                begin
                    if (diff[8*b +: 8] != 8'h00)
                    begin
                        beats.push_back(meter_beat(1'b1, b[1:0], meter_count[8*b +: 8]));
                    end
                end
                saved_count = meter_count;
            end
        end
        if (beats.size() == 0)
        begin
            beats.push_back(meter_beat(1'b0, 2'd0, 8'h00));
        end
        beats[beats.size()-1].last_result = 1'b1;
        foreach (beats[i])
        begin
            expected_beats.push_back(beats[i]);
        end
        n_samples++;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (steady_mode)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic lhm_pkg::in_item_t restore_item(input logic [31:0] value);
        lhm_pkg::in_item_t s;
        s.action         = lhm_pkg::ACT_RESTORE;
        s.seconds_now    = 16'($urandom);
        s.restored_value = value;
        return s;
    endfunction

    function automatic lhm_pkg::in_item_t seconds_item(input logic [15:0] secs);
        lhm_pkg::in_item_t s;
        s.action         = lhm_pkg::ACT_SECONDS;
        s.seconds_now    = secs;
        s.restored_value = $urandom;
        return s;
    endfunction

    function automatic lhm_pkg::in_item_t random_sample();
        lhm_pkg::in_item_t s;
        int unsigned       pick;
        logic [15:0]       offset;
        s = seconds_item(16'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 4)
        begin
            s = restore_item(lhm_pkg::COUNT_ERASED);
        end
        else if (pick < 8)
        begin
            s = restore_item(lhm_pkg::COUNT_MAX - $urandom_range(0, 8));
        end
        else if (pick < 11)
        begin
            // counts that sit just below a byte carry
            if ($urandom_range(0, 1) == 0)
            begin
                s = restore_item(($urandom & 32'h0036_ff00) | 32'h0000_00ff);
            end
            else
            begin
                s = restore_item(($urandom & 32'h0036_0000) | 32'h0000_ffff);
            end
        end
        else if (pick < 14)
        begin
            s = restore_item($urandom);
        end
        else if (pick >= 19)
        begin
            case ($urandom_range(0, 3))
                0: offset = tick_interval_reg - 16'd1;
                1: offset = tick_interval_reg;
                2: offset = tick_interval_reg + 16'($urandom_range(0, 5));
                default: offset = 16'($urandom_range(0, tick_interval_reg));
            endcase
            s.seconds_now = last_tick_secs + offset;
        end
        return s;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        n_errors++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("beat %0d %s got %0h expected %0h",
                                      n_beats, name, got, want));
        end
    endtask

    task automatic check_beat(input lhm_pkg::out_item_t got);
        lhm_pkg::out_item_t want;
        if (expected_beats.size() == 0)
        begin
            report_mismatch($sformatf("unexpected beat, count %0d", got.lifetime_count));
            return;
        end
        want = expected_beats.pop_front();
        n_beats++;
        if (want.write_valid)
        begin
            n_writes++;
        end
        compare_field("write_valid", 32'(got.write_valid), 32'(want.write_valid));
        compare_field("byte_index", 32'(got.byte_index), 32'(want.byte_index));
        compare_field("byte_data", 32'(got.byte_data), 32'(want.byte_data));
        compare_field("last_result", 32'(got.last_result), 32'(want.last_result));
        compare_field("lifetime_count", got.lifetime_count, want.lifetime_count);
        compare_field("hour_thousands_char", 32'(got.hour_thousands_char),
                      32'(want.hour_thousands_char));
        compare_field("hour_hundreds_char", 32'(got.hour_hundreds_char),
                      32'(want.hour_hundreds_char));
        compare_field("hour_tens_char", 32'(got.hour_tens_char),
                      32'(want.hour_tens_char));
        compare_field("hour_units_char", 32'(got.hour_units_char),
                      32'(want.hour_units_char));
        compare_field("minute_tens_char", 32'(got.minute_tens_char),
                      32'(want.minute_tens_char));
        compare_field("minute_units_char", 32'(got.minute_units_char),
                      32'(want.minute_units_char));
    endtask

    task automatic send_sample(input lhm_pkg::in_item_t s, input int unsigned gap);
        push    <= 1'b1;
        in_beat <= s;
        do
        begin
            @(posedge clk);
        end
        while (full);
        predict_meter(s);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic end_burst();
        push <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_idle();
        while (expected_beats.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [lhm_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [lhm_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        if (idx == lhm_pkg::CFG_TICK_INTERVAL)
        begin
            tick_interval_reg = data;
        end
        else if (idx == lhm_pkg::CFG_COUNT_ENABLE)
        begin
            count_enable_reg = data[0];
        end
        n_cfg_writes++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic finish_test();
        end_burst();
        wait_idle();
    endtask

    task automatic test_default_interval();
        send_sample(seconds_item(16'd5), pick_gap());
        send_sample(seconds_item(16'd10), pick_gap());
        send_sample(seconds_item(16'd19), pick_gap());
        finish_test();
    endtask

    task automatic test_erased_restore();
        send_sample(restore_item(lhm_pkg::COUNT_ERASED), pick_gap());
        send_sample(restore_item(32'd0), pick_gap());
        finish_test();
    endtask

    task automatic test_byte_carries();
        send_sample(restore_item(32'h0000_ffff), pick_gap());
        send_sample(seconds_item(last_tick_secs + tick_interval_reg), pick_gap());
        send_sample(restore_item(32'h0000_00ff), pick_gap());
        send_sample(seconds_item(last_tick_secs + tick_interval_reg), pick_gap());
        finish_test();
    endtask

    task automatic test_saturation();
        send_sample(restore_item(lhm_pkg::COUNT_MAX - 32'd1), pick_gap());
        send_sample(seconds_item(last_tick_secs + tick_interval_reg), pick_gap());
        send_sample(seconds_item(last_tick_secs + tick_interval_reg), pick_gap());
        send_sample(restore_item(32'hffff_fffe), pick_gap());
        send_sample(seconds_item(last_tick_secs + tick_interval_reg), pick_gap());
        finish_test();
    endtask

    task automatic test_display_extremes();
        send_sample(restore_item(32'd3599640), pick_gap());
        send_sample(restore_item(32'd359), pick_gap());
        send_sample(restore_item(32'd360000), pick_gap());
        finish_test();
    endtask

    task automatic test_interval_extremes();
        write_reg(lhm_pkg::CFG_TICK_INTERVAL, 16'd0);
        send_sample(seconds_item(last_tick_secs), pick_gap());
        send_sample(seconds_item(last_tick_secs), pick_gap());
        finish_test();
        write_reg(lhm_pkg::CFG_TICK_INTERVAL, 16'hffff);
        send_sample(seconds_item(last_tick_secs + 16'hfffe), pick_gap());
        send_sample(seconds_item(last_tick_secs + 16'hffff), pick_gap());
        finish_test();
        write_reg(lhm_pkg::CFG_TICK_INTERVAL, 16'd1);
        send_sample(seconds_item(last_tick_secs + 16'd1), pick_gap());
        finish_test();
        write_reg(lhm_pkg::CFG_TICK_INTERVAL, lhm_pkg::TICK_INTERVAL_RST);
    endtask

    task automatic test_counting_frozen();
        write_reg(lhm_pkg::CFG_COUNT_ENABLE, 16'd0);
        send_sample(seconds_item(last_tick_secs + tick_interval_reg + 16'd100), pick_gap());
        send_sample(restore_item(32'd42), pick_gap());
        finish_test();
        write_reg(lhm_pkg::CFG_COUNT_ENABLE, 16'd1);
        send_sample(seconds_item(last_tick_secs + tick_interval_reg), pick_gap());
        finish_test();
    endtask

    task automatic test_seconds_wrap();
        send_sample(seconds_item(16'd65530), pick_gap());
        send_sample(seconds_item(16'd4), pick_gap());
        send_sample(seconds_item(16'd13), pick_gap());
        finish_test();
    endtask

    task automatic test_backpressure();
        write_reg(lhm_pkg::CFG_TICK_INTERVAL, 16'd0);
        hold_request = 1'b1;
        for (int i = 0; i < 16; i++)
        begin
            if (i % 3 == 0)
            begin
                send_sample(restore_item(lhm_pkg::COUNT_ERASED), 0);
            end
            else
            begin
                send_sample(seconds_item(16'($urandom)), 0);
            end
        end
        finish_test();
    endtask

    task automatic test_random_phases();
        logic [15:0] intervals[RANDOM_PHASES];
        logic        enables[RANDOM_PHASES];
        intervals = '{16'd10, 16'd1, 16'd0, 16'hffff, 16'd3, 16'd3, 16'd20};
        enables   = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            write_reg(lhm_pkg::CFG_TICK_INTERVAL, intervals[p]);
            write_reg(lhm_pkg::CFG_COUNT_ENABLE, {15'd0, enables[p]});
            steady_mode = (p % 3 == 1);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                send_sample(random_sample(), pick_gap());
            end
            finish_test();
        end
        steady_mode = 1'b0;
    endtask

    // result side: random pop gaps, plus one long hold-off on request
    initial
    begin
        int unsigned stall;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                check_beat(out_beat);
                stall = pick_gap();
            end
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall = LONG_HOLD;
            end
            if (stall > 0)
            begin
                pop <= 1'b0;
                stall--;
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (push && full)
        begin
            full_stalls++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles, %0d beats outstanding",
                     idle_cycles, expected_beats.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_interval();
        test_erased_restore();
        test_byte_carries();
        test_saturation();
        test_display_extremes();
        test_interval_extremes();
        test_counting_frozen();
        test_seconds_wrap();
        test_backpressure();
        test_random_phases();
        wait_idle();
        $display("covered %0d samples (%0d restores), %0d result beats, %0d backup writes",
                 n_samples, n_restores, n_beats, n_writes);
        $display("%0d register writes, input held by full on %0d cycles, %0d mismatches",
                 n_cfg_writes, full_stalls, n_errors);
        if (n_errors == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
